// File: rtl/http_chunked_framing_parser_defines.svh
// assertion helpers for the chunked framing parser
`ifndef HTTP_CHUNKED_FRAMING_PARSER_DEFINES_SVH
`define HTTP_CHUNKED_FRAMING_PARSER_DEFINES_SVH

// clocked check, off while reset is asserted
`define HCFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds through reset
`define HCFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/hcfp_pkg.sv
`default_nettype none

package hcfp_pkg;

  // width of the chunk size accumulator
  localparam int unsigned SizeBits = 63;

  // width of the chunk size result field
  localparam int unsigned ChunkSizeW = 63;

  // framing characters
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;

  // result event codes
  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvChunk = 2'd1,
    EvEnd   = 2'd2,
    EvError = 2'd3
  } event_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  // decode one ascii hex digit
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    logic [7:0] diff;
    r    = '0;
    diff = '0;
    if (c >= ChZero && c <= ChNine) begin
      diff    = c - ChZero;
      r.valid = 1'b1;
      r.value = diff[3:0];
    end else if (c >= ChLowA && c <= ChLowF) begin
      diff    = c - ChLowA + 8'd10;
      r.valid = 1'b1;
      r.value = diff[3:0];
    end else if (c >= ChUpA && c <= ChUpF) begin
      diff    = c - ChUpA + 8'd10;
      r.valid = 1'b1;
      r.value = diff[3:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/http_chunked_framing_parser.sv
// A byte accepted at a clock edge has its result written to the output register at
// that edge. Throughput: one byte per cycle unless a held, stalled result stalls the
// input; the phase and size update is a single pass of logic between the input port
// and the result register. Reset (asynchronous, active low) returns the parser to the
// start of a size field with a zero size and empties the output register.
`default_nettype none

module http_chunked_framing_parser (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [7:0]                          byte_in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [1:0]                               event_res_o,
  output logic [hcfp_pkg::ChunkSizeW-1:0]          chunk_size_o,
  output logic                                     byte_taken_o
);

  `include "http_chunked_framing_parser_defines.svh"

  typedef enum logic [3:0] {
    PhSize    = 4'd0,
    PhExt     = 4'd1,
    PhSizeLf  = 4'd2,
    PhData    = 4'd3,
    PhDataLf  = 4'd4,
    PhTrailer = 4'd5,
    PhTrlLine = 4'd6,
    PhTrlLf   = 4'd7,
    PhLastLf  = 4'd8,
    PhDone    = 4'd9,
    PhError   = 4'd10
  } phase_e;

  localparam int unsigned SzW = hcfp_pkg::SizeBits;

  phase_e                          phase_q, phase_d;
  logic [SzW-1:0]                  accum_q, accum_d;
  logic                            out_valid_q, out_valid_d;
  hcfp_pkg::event_e                event_q, event_d;
  logic [hcfp_pkg::ChunkSizeW-1:0] size_q, size_d;
  logic                            taken_q, taken_d;

  logic                            in_xfer;
  logic                            out_xfer;
  phase_e                          eff_phase;
  logic [SzW-1:0]                  eff_accum;
  logic                            is_cr, is_lf, is_ext;
  logic                            size_zero;
  logic                            size_ovf;
  hcfp_pkg::hex_digit_t            hex;
  phase_e                          line_phase;
  hcfp_pkg::event_e                line_event;

  // handshake: take a byte unless a result is held and stalled
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_xfer   = out_valid_q & ~out_stall_i;

  // byte classes
  assign is_cr  = (byte_in_i == hcfp_pkg::ChCr);
  assign is_lf  = (byte_in_i == hcfp_pkg::ChLf);
  assign is_ext = (byte_in_i == hcfp_pkg::ChSemi) || (byte_in_i == hcfp_pkg::ChSpace) ||
                  (byte_in_i == hcfp_pkg::ChTab);
  assign hex    = hcfp_pkg::hex_decode(byte_in_i);

  // missing lf after cr: the byte is parsed in the phase that follows (untaken if size != 0)
  always_comb begin
    eff_phase = phase_q;
    eff_accum = accum_q;
    if (!is_lf) begin
      if (phase_q == PhSizeLf && accum_q == '0) begin
        eff_phase = PhTrailer;
      end else if (phase_q == PhDataLf) begin
        eff_phase = PhSize;
        eff_accum = '0;
      end else if (phase_q == PhTrlLf) begin
        eff_phase = PhTrailer;
      end
    end
  end

  // end of size line: zero starts trailers, nonzero announces a chunk
  assign size_zero  = (eff_accum == '0);
  assign size_ovf   = |eff_accum[SzW-1 -: 4];
  assign line_phase = size_zero ? PhTrailer : PhData;
  assign line_event = size_zero ? hcfp_pkg::EvNone : hcfp_pkg::EvChunk;

  // phase transition and result for one byte
  always_comb begin
    phase_d = eff_phase;
    accum_d = eff_accum;
    event_d = hcfp_pkg::EvNone;
    size_d  = '0;
    taken_d = 1'b0;
    unique case (eff_phase)
      PhSize: begin
        if (size_ovf) begin
          phase_d = PhError;
          event_d = hcfp_pkg::EvError;
        end else if (hex.valid) begin
          accum_d = {eff_accum[SzW-5:0], hex.value};
          taken_d = 1'b1;
        end else if (is_cr) begin
          phase_d = PhSizeLf;
          taken_d = 1'b1;
        end else if (is_lf) begin
          phase_d = line_phase;
          event_d = line_event;
          size_d  = hcfp_pkg::ChunkSizeW'(eff_accum);
          taken_d = 1'b1;
        end else if (is_ext) begin
          phase_d = PhExt;
          taken_d = 1'b1;
        end else begin
          phase_d = PhError;
          event_d = hcfp_pkg::EvError;
        end
      end
      PhExt: begin
        taken_d = 1'b1;
        if (is_cr) begin
          phase_d = PhSizeLf;
        end else if (is_lf) begin
          phase_d = line_phase;
          event_d = line_event;
          size_d  = hcfp_pkg::ChunkSizeW'(eff_accum);
        end
      end
      PhSizeLf: begin
        // a zero size without lf was already moved to the trailer phase
        phase_d = line_phase;
        event_d = line_event;
        size_d  = hcfp_pkg::ChunkSizeW'(eff_accum);
        taken_d = is_lf;
      end
      PhData: begin
        taken_d = 1'b1;
        if (is_cr) begin
          phase_d = PhDataLf;
        end else if (is_lf) begin
          phase_d = PhSize;
          accum_d = '0;
        end else begin
          phase_d = PhError;
          event_d = hcfp_pkg::EvError;
        end
      end
      PhDataLf: begin
        phase_d = PhSize;
        accum_d = '0;
        taken_d = 1'b1;
      end
      PhTrailer: begin
        taken_d = 1'b1;
        if (is_cr) begin
          phase_d = PhLastLf;
        end else if (is_lf) begin
          phase_d = PhDone;
          event_d = hcfp_pkg::EvEnd;
        end else begin
          phase_d = PhTrlLine;
        end
      end
      PhTrlLine: begin
        taken_d = 1'b1;
        if (is_cr) begin
          phase_d = PhTrlLf;
        end else if (is_lf) begin
          phase_d = PhTrailer;
        end
      end
      PhTrlLf: begin
        phase_d = PhTrailer;
        taken_d = 1'b1;
      end
      PhLastLf: begin
        phase_d = PhDone;
        event_d = hcfp_pkg::EvEnd;
        taken_d = is_lf;
      end
      PhDone: begin
        phase_d = PhDone;
      end
      default: begin
        phase_d = PhError;
        event_d = hcfp_pkg::EvError;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  // parser state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSize;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
      event_q     <= hcfp_pkg::EvNone;
      size_q      <= '0;
      taken_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        phase_q <= phase_d;
        accum_q <= accum_d;
        event_q <= event_d;
        size_q  <= size_d;
        taken_q <= taken_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = event_q;
  assign chunk_size_o = size_q;
  assign byte_taken_o = taken_q;

  // checks
  `HCFP_ASSERT(a_error_sticky,
    in_xfer && phase_q == PhError |=> out_valid_q && event_q == hcfp_pkg::EvError && !taken_q,
    "error phase did not report an untaken error")
  `HCFP_ASSERT(a_chunk_nonzero,
    out_valid_q && event_q == hcfp_pkg::EvChunk |-> size_q != '0,
    "chunk header reported with zero size")
  `HCFP_ASSERT(a_done_holds,
    phase_q == PhDone |=> phase_q == PhDone,
    "parser left the end of body phase")
  `HCFP_ASSERT(a_idle_state,
    !in_xfer |=> $stable(phase_q) && $stable(accum_q),
    "parser state moved without a byte transfer")
  `HCFP_ASSERT_ALWAYS(a_reset_empty,
    !rst_ni |=> !out_valid_q,
    "output register not empty during reset")

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  // parser phases tracked by the prediction
  typedef enum logic [3:0] {
    PhSize,
    PhExt,
    PhSizeLf,
    PhData,
    PhDataLf,
    PhTrailer,
    PhTrlLine,
    PhTrlLf,
    PhLastLf,
    PhDone,
    PhError
  } parse_phase_e;

  typedef logic [hcfp_pkg::SizeBits-1:0] chunk_len_t;

  // one predicted result transfer
  typedef struct packed {
    hcfp_pkg::event_e                ev;
    logic [hcfp_pkg::ChunkSizeW-1:0] size;
    logic                            taken;
  } frame_result_t;

  // line end styles used when building the byte stream
  localparam int unsigned EndCrLf = 0;
  localparam int unsigned EndLf   = 1;
  localparam int unsigned EndCr   = 2;

  localparam int unsigned RandomItems = 500;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 400;

  // largest size that may still take one more hex digit
  localparam chunk_len_t SizeGuard = {hcfp_pkg::SizeBits{1'b1}} >> 4;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  logic [7:0]                      byte_in   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      event_res;
  logic [hcfp_pkg::ChunkSizeW-1:0] chunk_size;
  logic                            byte_taken;

  http_chunked_framing_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .byte_in_i    (byte_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .event_res_o  (event_res),
    .chunk_size_o (chunk_size),
    .byte_taken_o (byte_taken)
  );

  // bytes waiting to be offered and results waiting to be seen
  logic [7:0]    framing_bytes[$];
  frame_result_t framing_results_q[$];

  // predicted parser state
  parse_phase_e parse_phase = PhSize;
  chunk_len_t   size_acc    = '0;

  int unsigned bytes_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned chunks_seen    = 0;
  int unsigned ends_seen      = 0;
  int unsigned errors_seen    = 0;
  int unsigned handed_on      = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  int unsigned   burst_left = 0;
  int unsigned   gap_left   = 0;
  int unsigned   hold_left  = 0;
  int unsigned   mode_left  = 0;
  int unsigned   stall_mode = 0;
  logic          held_once  = 1'b0;
  frame_result_t want;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // a size line is complete: zero starts the trailer, nonzero reports a header
  function automatic frame_result_t close_size_line(input frame_result_t r);
    frame_result_t o;
    o = r;
    if (size_acc == '0) begin
      parse_phase = PhTrailer;
    end else begin
      parse_phase = PhData;
      o.ev        = hcfp_pkg::EvChunk;
      o.size      = size_acc;
    end
    return o;
  endfunction

  // advance the predicted parser by one byte
  function automatic frame_result_t parse_framing_byte(input logic [7:0] c);
    frame_result_t r;
    logic          reparse;
    logic          is_hex;
    logic [7:0]    nib;
    r      = '0;
    r.ev   = hcfp_pkg::EvNone;
    is_hex = 1'b1;
    nib    = '0;
    if (c >= hcfp_pkg::ChZero && c <= hcfp_pkg::ChNine) nib = c - hcfp_pkg::ChZero;
    else if (c >= hcfp_pkg::ChLowA && c <= hcfp_pkg::ChLowF)
      nib = c - hcfp_pkg::ChLowA + 8'd10;
    else if (c >= hcfp_pkg::ChUpA && c <= hcfp_pkg::ChUpF)
      nib = c - hcfp_pkg::ChUpA + 8'd10;
    else is_hex = 1'b0;
    reparse = 1'b1;
    while (reparse) begin
      reparse = 1'b0;
      case (parse_phase)
        PhSize: begin
          if (size_acc > SizeGuard) begin
            parse_phase = PhError;
            r.ev        = hcfp_pkg::EvError;
          end else if (is_hex) begin
            size_acc = {size_acc[hcfp_pkg::SizeBits-5:0], nib[3:0]};
            r.taken  = 1'b1;
          end else if (c == hcfp_pkg::ChCr) begin
            parse_phase = PhSizeLf;
            r.taken     = 1'b1;
          end else if (c == hcfp_pkg::ChLf) begin
            r.taken = 1'b1;
            r       = close_size_line(r);
          end else if (c == hcfp_pkg::ChSemi || c == hcfp_pkg::ChSpace ||
                       c == hcfp_pkg::ChTab) begin
            parse_phase = PhExt;
            r.taken     = 1'b1;
          end else begin
            parse_phase = PhError;
            r.ev        = hcfp_pkg::EvError;
          end
        end
        PhExt: begin
          r.taken = 1'b1;
          if (c == hcfp_pkg::ChCr) parse_phase = PhSizeLf;
          else if (c == hcfp_pkg::ChLf) r = close_size_line(r);
        end
        PhSizeLf: begin
          if (c == hcfp_pkg::ChLf) begin
            r.taken = 1'b1;
            r       = close_size_line(r);
          end else begin
            // missing lf: a zero size parses this byte as trailer at once
            r       = close_size_line(r);
            reparse = (parse_phase == PhTrailer);
          end
        end
        PhData: begin
          r.taken = 1'b1;
          if (c == hcfp_pkg::ChCr) begin
            parse_phase = PhDataLf;
          end else if (c == hcfp_pkg::ChLf) begin
            parse_phase = PhSize;
            size_acc    = '0;
          end else begin
            parse_phase = PhError;
            r.ev        = hcfp_pkg::EvError;
          end
        end
        PhDataLf: begin
          parse_phase = PhSize;
          size_acc    = '0;
          if (c == hcfp_pkg::ChLf) r.taken = 1'b1;
          else reparse = 1'b1;
        end
        PhTrailer: begin
          r.taken = 1'b1;
          if (c == hcfp_pkg::ChCr) begin
            parse_phase = PhLastLf;
          end else if (c == hcfp_pkg::ChLf) begin
            parse_phase = PhDone;
            r.ev        = hcfp_pkg::EvEnd;
          end else begin
            parse_phase = PhTrlLine;
          end
        end
        PhTrlLine: begin
          r.taken = 1'b1;
          if (c == hcfp_pkg::ChCr) parse_phase = PhTrlLf;
          else if (c == hcfp_pkg::ChLf) parse_phase = PhTrailer;
        end
        PhTrlLf: begin
          parse_phase = PhTrailer;
          if (c == hcfp_pkg::ChLf) r.taken = 1'b1;
          else reparse = 1'b1;
        end
        PhLastLf: begin
          parse_phase = PhDone;
          r.ev        = hcfp_pkg::EvEnd;
          if (c == hcfp_pkg::ChLf) r.taken = 1'b1;
        end
        PhDone: ;
        default: begin
          // sticky error
          parse_phase = PhError;
          r.ev        = hcfp_pkg::EvError;
          r.taken     = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

  // stream building helpers
  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) framing_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] random_text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == hcfp_pkg::ChCr || b == hcfp_pkg::ChLf) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return hcfp_pkg::ChZero + n;
    return ($urandom_range(0, 1) ? hcfp_pkg::ChLowA : hcfp_pkg::ChUpA) + n - 8'd10;
  endfunction

  function automatic void push_line_end(input int unsigned style);
    if (style != EndLf) framing_bytes.push_back(hcfp_pkg::ChCr);
    if (style != EndCr) framing_bytes.push_back(hcfp_pkg::ChLf);
  endfunction

  function automatic void push_size_line(input chunk_len_t sz,
                                         input int unsigned lead, input int unsigned style);
    logic [63:0] v;
    logic [7:0]  sep;
    int          top;
    v   = {1'b0, sz};
    top = -1;
    for (int n = 0; n < 16; n++) if (v[n*4 +: 4] != 4'd0) top = n;
    repeat (lead) framing_bytes.push_back(hcfp_pkg::ChZero);
    for (int n = top; n >= 0; n--) framing_bytes.push_back(hex_char(v[n*4 +: 4]));
    // optional extension with arbitrary content up to the line end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0:       sep = hcfp_pkg::ChSemi;
        1:       sep = hcfp_pkg::ChSpace;
        default: sep = hcfp_pkg::ChTab;
      endcase
      framing_bytes.push_back(sep);
      repeat ($urandom_range(0, 6)) framing_bytes.push_back(random_text_byte());
    end
    push_line_end(style);
  endfunction

  function automatic chunk_len_t random_chunk_size();
    logic [63:0] wide;
    chunk_len_t  v;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0:          v = wide[hcfp_pkg::SizeBits-1:0] & SizeGuard;
      1, 2:       v = chunk_len_t'(wide[31:0]);
      3, 4, 5, 6: v = chunk_len_t'($urandom_range(1, 16'hffff));
      default:    v = chunk_len_t'($urandom_range(1, 255));
    endcase
    if (v == '0) v = chunk_len_t'(1);
    return v;
  endfunction

  // one chunk header followed by the line end of its data
  function automatic void push_chunk(input chunk_len_t sz);
    int unsigned style;
    style = $urandom_range(EndCrLf, EndCr);
    push_size_line(sz, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0, style);
    // without the lf the next byte comes back with the header as first data byte
    if (style == EndCr) framing_bytes.push_back(random_text_byte());
    push_line_end($urandom_range(EndCrLf, EndCr));
  endfunction

  // stimulus and end of run
  initial begin
    int unsigned base_len;
    string       finale_desc;
    // mixed case hex, crlf endings
    push_text("Ff\015\n\015\n");
    // extension with a high byte, cr without lf, data end by lf only
    push_text("a;\377\015Z\n");
    // largest size that can be closed, tab extension, data end by lone cr
    push_text("7FFFFFFFFFFFFFF\t\n\015");

    // well-formed chunks with random sizes, extensions and line ends
    base_len = framing_bytes.size();
    while (framing_bytes.size() < base_len + RandomItems) push_chunk(random_chunk_size());

    // end of body and errors are both final until reset, so one closes the stream
    case ($urandom_range(0, 5))
      3: begin
        finale_desc = "bad byte in size field";
        repeat ($urandom_range(0, 3))
          framing_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        begin
          logic [7:0] b;
          b = 8'($urandom_range(0, 255));
          while ((b >= hcfp_pkg::ChZero && b <= hcfp_pkg::ChNine) ||
                 (b >= hcfp_pkg::ChLowA && b <= hcfp_pkg::ChLowF) ||
                 (b >= hcfp_pkg::ChUpA && b <= hcfp_pkg::ChUpF) ||
                 b == hcfp_pkg::ChCr || b == hcfp_pkg::ChLf ||
                 b == hcfp_pkg::ChSemi || b == hcfp_pkg::ChSpace || b == hcfp_pkg::ChTab)
            b = 8'($urandom_range(0, 255));
          framing_bytes.push_back(b);
        end
      end
      4: begin
        finale_desc = "size overflow";
        framing_bytes.push_back(hex_char(4'($urandom_range(8, 15))));
        repeat (14) framing_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        framing_bytes.push_back(8'($urandom_range(0, 255)));
      end
      5: begin
        finale_desc = "bad data end";
        push_size_line(random_chunk_size(), 0, EndCrLf);
        framing_bytes.push_back(random_text_byte());
      end
      default: begin
        finale_desc = "end of body";
        push_size_line('0, $urandom_range(0, 2), $urandom_range(EndCrLf, EndCr));
        repeat ($urandom_range(0, 3)) begin
          repeat ($urandom_range(1, 8)) framing_bytes.push_back(random_text_byte());
          push_line_end($urandom_range(EndCrLf, EndCr));
        end
        push_line_end($urandom_range(EndCrLf, EndCr));
        framing_bytes.push_back(random_text_byte());
      end
    endcase
    // bytes after the stream is closed
    repeat (12) framing_bytes.push_back(8'($urandom_range(0, 255)));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (framing_bytes.size() != 0 || in_valid) @(posedge clk_i);
    while (framing_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("fed %0d bytes, checked %0d results: %0d chunk headers, %0d end of body, %0d error",
             bytes_accepted, results_seen, chunks_seen, ends_seen, errors_seen);
    $display("%0d bytes handed on, stream closed by %s", handed_on, finale_desc);
    if (mismatches == 0) begin
      $display("[http_chunked_framing_parser] OK");
    end else begin
      $display("[http_chunked_framing_parser] ERROR");
    end
    $finish;
  end

  // byte driver: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      byte_in     <= '0;
      burst_left  = 0;
      gap_left    = 0;
      parse_phase = PhSize;
      size_acc    = '0;
    end else begin
      // transfer of the current byte
      if (in_valid && !in_stall) begin
        framing_results_q.push_back(parse_framing_byte(byte_in));
        bytes_accepted++;
      end
      // the offered byte holds while stalled
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (framing_bytes.size() > 0) begin
          in_valid <= 1'b1;
          byte_in  <= framing_bytes.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (framing_results_q.size() == 0) begin
          $error("result transfer with nothing expected: event_res %0d", event_res);
          mismatches++;
        end else begin
          want = framing_results_q.pop_front();
          if (event_res !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, event_res);
            mismatches++;
          end
          if (chunk_size !== want.size) begin
            $error("chunk_size: expected %0h, got %0h", want.size, chunk_size);
            mismatches++;
          end
          if (byte_taken !== want.taken) begin
            $error("byte_taken: expected %0d, got %0d", want.taken, byte_taken);
            mismatches++;
          end
          if (want.ev == hcfp_pkg::EvChunk) chunks_seen++;
          if (want.ev == hcfp_pkg::EvEnd) ends_seen++;
          if (want.ev == hcfp_pkg::EvError) errors_seen++;
          if (!want.taken) handed_on++;
        end
      end
      // one long hold-off so the parser backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_once && results_seen >= 150) begin
        held_once = 1'b1;
        hold_left = HoldCycles;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(20, 120);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 4) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timed out after %0d cycles with %0d results pending",
               cycle_count, framing_results_q.size());
      $display("[http_chunked_framing_parser] ERROR");
      $finish;
    end
  end

endmodule
